>>> design/fpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types, widths and plane helpers for the frustum plane extractor.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 1;
    localparam int MAG_W     = SUM_W;
    localparam int RAD_W     = 68;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NUM_W     = SUM_W + FRAC_BITS + 1;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] PLANE_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] PLANE_RIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] PLANE_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] PLANE_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] PLANE_NEAR   = 3'd4;
    localparam logic [IDX_W-1:0] PLANE_FAR    = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] row0_value;
        logic signed [DATA_W-1:0] row1_value;
        logic signed [DATA_W-1:0] row2_value;
        logic signed [DATA_W-1:0] row3_value;
        logic                     final_column;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         plane_index;
        logic signed [DATA_W-1:0] plane_a;
        logic signed [DATA_W-1:0] plane_b;
        logic signed [DATA_W-1:0] plane_c;
        logic signed [DATA_W-1:0] plane_d;
        logic                     degenerate;
        logic                     last_plane;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0]          index;
        logic [3:0][SUM_W-1:0]     s;
    } t_job;

    typedef enum logic {FS_IDLE, FS_EMIT} t_front_state;

    typedef enum logic [2:0] {BS_IDLE, BS_SQUARE, BS_ROOT, BS_DIV, BS_OUT} t_back_state;

    function automatic logic [1:0] plane_row(input logic [IDX_W-1:0] idx);
        logic [1:0] r;
        case (idx)
            PLANE_LEFT, PLANE_RIGHT:  r = 2'd0;
            PLANE_TOP, PLANE_BOTTOM:  r = 2'd1;
            default:                  r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic plane_sub(input logic [IDX_W-1:0] idx);
        logic r;
        case (idx)
            PLANE_RIGHT, PLANE_TOP, PLANE_FAR: r = 1'b1;
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic [SUM_W-1:0] s);
        return s[SUM_W-1] ? (~s + 1'b1) : s;
    endfunction

endpackage

>>> design/fpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_front
// Column store and counter; on the final column, queues six plane jobs.
// ----------------------------------------------------------------------------
module fpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fpe_pkg::t_in_item i_in,
    output logic              o_busy,
    input  logic              i_full,
    output logic              o_push,
    output fpe_pkg::t_job     o_job
);

    logic [fpe_pkg::DATA_W-1:0] r_mat [4][4];
    fpe_pkg::t_front_state      r_state, n_state;
    logic [1:0]                 r_col, n_col;
    logic [fpe_pkg::IDX_W-1:0]  r_pidx, n_pidx;
    logic                       w_accept;
    logic [1:0]                 w_row;
    logic                       w_sub;

    assign o_busy   = (r_state != fpe_pkg::FS_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_row    = fpe_pkg::plane_row(r_pidx);
    assign w_sub    = fpe_pkg::plane_sub(r_pidx);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mat[r_col][0] <= i_in.row0_value;
            r_mat[r_col][1] <= i_in.row1_value;
            r_mat[r_col][2] <= i_in.row2_value;
            r_mat[r_col][3] <= i_in.row3_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpe_pkg::FS_IDLE;
            r_col   <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_pidx  <= n_pidx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_pidx  = r_pidx;
        o_push  = 1'b0;
        case (r_state)
            fpe_pkg::FS_IDLE: begin
                if (w_accept) begin
                    if (i_in.final_column) begin
                        n_col   = '0;
                        n_pidx  = fpe_pkg::PLANE_LEFT;
                        n_state = fpe_pkg::FS_EMIT;
                    end else begin
                        n_col = r_col + 2'd1;
                    end
                end
            end
            fpe_pkg::FS_EMIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    if (r_pidx == fpe_pkg::PLANE_FAR) begin
                        n_state = fpe_pkg::FS_IDLE;
                    end else begin
                        n_pidx = r_pidx + 3'd1;
                    end
                end
            end
            default: n_state = fpe_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        o_job.index = r_pidx;
        for (int i = 0; i < 4; i++) begin
            o_job.s[i] = w_sub
                ? ({r_mat[i][3][31], r_mat[i][3]} - {r_mat[i][w_row][31], r_mat[i][w_row]})
                : ({r_mat[i][3][31], r_mat[i][3]} + {r_mat[i][w_row][31], r_mat[i][w_row]});
        end
    end

endmodule

>>> design/fpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_queue
// Two-entry job queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module fpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpe_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output fpe_pkg::t_job o_job
);

    fpe_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/fpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_back
// Per plane: serial sum of squares, digit-by-digit root, four restoring
// divisions with rounding and saturation.
// ----------------------------------------------------------------------------
module fpe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  fpe_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               strobe,
    output fpe_pkg::t_out_item o_out
);

    fpe_pkg::t_back_state                 r_state, n_state;
    logic [fpe_pkg::IDX_W-1:0]            r_idx, n_idx;
    logic [3:0][fpe_pkg::SUM_W-1:0]       r_s, n_s;
    logic [1:0]                           r_comp, n_comp;
    logic [fpe_pkg::CNT_W-1:0]            r_cnt, n_cnt;
    logic [fpe_pkg::RAD_W-1:0]            r_acc, n_acc;
    logic [fpe_pkg::RAD_W-1:0]            r_mcand, n_mcand;
    logic [fpe_pkg::MAG_W-1:0]            r_mplier, n_mplier;
    logic [fpe_pkg::REM_W-1:0]            r_rem, n_rem;
    logic [fpe_pkg::ROOT_W-1:0]           r_root, n_root;
    logic [fpe_pkg::NUM_W-1:0]            r_num, n_num;
    logic [fpe_pkg::DREM_W-1:0]           r_drem, n_drem;
    logic [3:0][fpe_pkg::DATA_W-1:0]      r_res, n_res;
    logic                                 r_deg, n_deg;

    logic [fpe_pkg::REM_W-1:0]            w_rsh, w_trial;
    logic [fpe_pkg::DREM_W-1:0]           w_dsh;
    logic [fpe_pkg::NUM_W-1:0]            w_q;
    logic [fpe_pkg::DATA_W-1:0]           w_sat;
    logic [1:0]                           w_next_comp;

    function automatic logic [fpe_pkg::NUM_W-1:0] num_init(
        input logic [fpe_pkg::SUM_W-1:0]  s,
        input logic [fpe_pkg::ROOT_W-1:0] len
    );
        logic [fpe_pkg::NUM_W-1:0] a;
        logic [fpe_pkg::NUM_W-1:0] b;
        a = {1'b0, fpe_pkg::mag(s), {fpe_pkg::FRAC_BITS{1'b0}}};
        b = fpe_pkg::NUM_W'(len >> 1);
        return a + b;
    endfunction

    assign strobe = (r_state == fpe_pkg::BS_OUT);
    assign o_out.plane_index = r_idx;
    assign o_out.plane_a     = r_res[0];
    assign o_out.plane_b     = r_res[1];
    assign o_out.plane_c     = r_res[2];
    assign o_out.plane_d     = r_res[3];
    assign o_out.degenerate  = r_deg;
    assign o_out.last_plane  = (r_idx == fpe_pkg::PLANE_FAR);

    assign w_next_comp = r_comp + 2'd1;
    assign w_rsh   = {r_rem[fpe_pkg::REM_W-3:0], r_acc[fpe_pkg::RAD_W-1 -: 2]};
    assign w_trial = fpe_pkg::REM_W'({r_root, 2'b01});
    assign w_dsh   = {r_drem[fpe_pkg::DREM_W-2:0], r_num[fpe_pkg::NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpe_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx    <= n_idx;
        r_s      <= n_s;
        r_comp   <= n_comp;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_num    <= n_num;
        r_drem   <= n_drem;
        r_res    <= n_res;
        r_deg    <= n_deg;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_s      = r_s;
        n_comp   = r_comp;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_rem    = r_rem;
        n_root   = r_root;
        n_num    = r_num;
        n_drem   = r_drem;
        n_res    = r_res;
        n_deg    = r_deg;
        o_pop    = 1'b0;
        w_q      = '0;
        w_sat    = '0;
        case (r_state)
            fpe_pkg::BS_IDLE: begin
                if (i_avail) begin
                    o_pop    = 1'b1;
                    n_idx    = i_job.index;
                    n_s      = i_job.s;
                    n_comp   = '0;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_mcand  = fpe_pkg::RAD_W'(fpe_pkg::mag(i_job.s[0]));
                    n_mplier = fpe_pkg::mag(i_job.s[0]);
                    n_state  = fpe_pkg::BS_SQUARE;
                end
            end
            fpe_pkg::BS_SQUARE: begin
                // shift-add square, one multiplier bit per cycle
                if (r_mplier[0]) n_acc = r_acc + r_mcand;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == fpe_pkg::CNT_W'(fpe_pkg::MAG_W - 1)) begin
                    n_cnt = '0;
                    if (r_comp == 2'd2) begin
                        n_rem   = '0;
                        n_root  = '0;
                        n_state = fpe_pkg::BS_ROOT;
                    end else begin
                        n_comp   = w_next_comp;
                        n_mcand  = fpe_pkg::RAD_W'(fpe_pkg::mag(r_s[w_next_comp]));
                        n_mplier = fpe_pkg::mag(r_s[w_next_comp]);
                    end
                end
            end
            fpe_pkg::BS_ROOT: begin
                // two radicand bits per cycle
                n_acc = r_acc << 2;
                if (w_rsh >= w_trial) begin
                    n_rem  = w_rsh - w_trial;
                    n_root = {r_root[fpe_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_rsh;
                    n_root = {r_root[fpe_pkg::ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == fpe_pkg::CNT_W'(fpe_pkg::ROOT_W - 1)) begin
                    n_cnt = '0;
                    if (n_root == '0) begin
                        n_res   = '0;
                        n_deg   = 1'b1;
                        n_state = fpe_pkg::BS_OUT;
                    end else begin
                        n_deg   = 1'b0;
                        n_comp  = '0;
                        n_drem  = '0;
                        n_num   = num_init(r_s[0], n_root);
                        n_state = fpe_pkg::BS_DIV;
                    end
                end
            end
            fpe_pkg::BS_DIV: begin
                // restoring division; quotient bits shift into r_num
                if (w_dsh >= {1'b0, r_root}) begin
                    n_drem = w_dsh - {1'b0, r_root};
                    n_num  = {r_num[fpe_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    n_drem = w_dsh;
                    n_num  = {r_num[fpe_pkg::NUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == fpe_pkg::CNT_W'(fpe_pkg::NUM_W - 1)) begin
                    n_cnt = '0;
                    w_q   = n_num;
                    if (r_s[r_comp][fpe_pkg::SUM_W-1]) begin
                        if (w_q > fpe_pkg::NUM_W'(64'h8000_0000)) w_sat = 32'h8000_0000;
                        else w_sat = ~w_q[fpe_pkg::DATA_W-1:0] + 1'b1;
                    end else begin
                        if (w_q > fpe_pkg::NUM_W'(64'h7FFF_FFFF)) w_sat = 32'h7FFF_FFFF;
                        else w_sat = w_q[fpe_pkg::DATA_W-1:0];
                    end
                    n_res[r_comp] = w_sat;
                    if (r_comp == 2'd3) begin
                        n_state = fpe_pkg::BS_OUT;
                    end else begin
                        n_comp = w_next_comp;
                        n_drem = '0;
                        n_num  = num_init(r_s[w_next_comp], r_root);
                    end
                end
            end
            fpe_pkg::BS_OUT: begin
                n_state = fpe_pkg::BS_IDLE;
            end
            default: n_state = fpe_pkg::BS_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && o_out.degenerate |-> o_out.plane_a == 0 && o_out.plane_b == 0
            && o_out.plane_c == 0 && o_out.plane_d == 0)
        else $error("degenerate plane with non-zero coefficients");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |=> !strobe)
        else $error("back-to-back plane beats");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == fpe_pkg::BS_SQUARE)
        else $error("job popped but squaring not started");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> o_out.plane_index <= fpe_pkg::PLANE_FAR)
        else $error("plane index out of range");
`endif

endmodule

>>> design/frustum_plane_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_extract
// Loads a view-projection matrix one column per beat and emits the six
// normalised frustum planes after the final column.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  columns   i_in (t_in_item)          start high, busy low
//  planes    o_out (t_out_item)        strobe, one cycle, no back-pressure
//
//  A column that is not final leaves busy low. The final column holds busy
//  high until the sixth plane job has entered the two-entry queue.
//  Each plane passes through the back end's serial squarer, root and
//  divider (a degenerate plane skips the divider), and the back end takes
//  a new plane job only once the previous plane is out. The plane receiver
//  cannot stall.
//  Synchronous active-low reset clears the column counter and both sequencers.
// ----------------------------------------------------------------------------
module frustum_plane_extract (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fpe_pkg::t_in_item  i_in,
    output logic               strobe,
    output fpe_pkg::t_out_item o_out
);

    logic          w_push, w_full, w_pop, w_avail;
    fpe_pkg::t_job w_job_in, w_job_out;

    fpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_in    (i_in),
        .o_busy  (busy),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    fpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_job   (w_job_out)
    );

    fpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .strobe  (strobe),
        .o_out   (o_out)
    );

endmodule
